// ----- sv/sine_path_velocity_command_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sine path velocity command unit
// Shared wrappers so every assertion samples clk_i; SPVC_ASSERT is also gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef SINE_PATH_VELOCITY_COMMAND_UNIT_ASSERT_SVH
`define SINE_PATH_VELOCITY_COMMAND_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define SPVC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SPVC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/spvc_pkg.sv -----
// ----------------------------------------------------------------------------
// spvc_pkg
// Constants shared by the sine path velocity command unit and its checker.
// ----------------------------------------------------------------------------
package spvc_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_SPEED   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_AMP     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OSC_FREQ    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WB      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OSC_DELAY   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_X     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_X      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_START_SPEED = 4'd7;

  // Register reset values.
  localparam logic [15:0] RST_FWD_SPEED   = 16'd13107;
  localparam logic [15:0] RST_LAT_AMP     = 16'd5243;
  localparam logic [19:0] RST_OSC_FREQ    = 20'd52429;
  localparam logic [23:0] RST_INV_WB      = 24'd218453;
  localparam logic [31:0] RST_OSC_DELAY   = 32'd163840;
  localparam logic [22:0] RST_START_X     = 23'd32768;
  localparam logic [22:0] RST_STOP_X      = 23'd262144;
  localparam logic [15:0] RST_START_SPEED = 16'd13107;

  // Phase codes.
  localparam logic [1:0] PHASE_START = 2'd0;
  localparam logic [1:0] PHASE_OSC   = 2'd1;
  localparam logic [1:0] PHASE_STOP  = 2'd2;

  // Angle constants in Q30.
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;

  // floor(2^62 / 2pi_q30): quotient estimate for the range reduction.
  localparam logic [29:0] RED_RECIP = 30'((64'd1 << 62) / 64'd6746518852);

  // Series divisors 110, 72, 42, 20, 6 as ceil(2^40 / k).
  localparam int unsigned POLY_STEPS = 5;
  localparam int unsigned RECIP_SH   = 40;
  localparam logic [37:0] POLY_RECIP [0:POLY_STEPS-1] = '{
    38'(((64'd1 << 40) + 64'd109) / 64'd110),
    38'(((64'd1 << 40) + 64'd71) / 64'd72),
    38'(((64'd1 << 40) + 64'd41) / 64'd42),
    38'(((64'd1 << 40) + 64'd19) / 64'd20),
    38'(((64'd1 << 40) + 64'd5) / 64'd6)
  };

  // Divider quotient bits.
  localparam int unsigned DIV_QBITS = 17;

  // Latencies in cycles from the input register to the output register.
  localparam int unsigned SINE_LAT   = 6 + 3 * POLY_STEPS + 1;
  localparam int unsigned DIV_LAT    = DIV_QBITS + 2;
  localparam int unsigned PIPE_DEPTH = 2 + SINE_LAT + 5;

  // Output saturation limits.
  localparam logic signed [20:0] LIN_MAX  = 21'sd524287;
  localparam logic signed [20:0] LIN_MIN  = -21'sd524288;
  localparam logic signed [29:0] TURN_MAX = 30'sd2097151;
  localparam logic signed [29:0] TURN_MIN = -30'sd2097152;

endpackage

// ----- sv/sine_path_velocity_command_unit.sv -----
// ----------------------------------------------------------------------------
// sine_path_velocity_command_unit
// Throughput: one word per cycle; the whole pipeline advances together and
// holds only while the output word is valid and stalled.
// Reset: asynchronous, active low; clears the valid bits and loads the
// register defaults. Configuration writes are always ready.
// ----------------------------------------------------------------------------
module sine_path_velocity_command_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic        [31:0] elapsed_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [19:0] linear_speed_o,
  output logic signed [21:0] turn_rate_o,
  output logic        [1:0]  phase_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [spvc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [31:0] cfg_data_i
);
  import spvc_pkg::*;

  // The yaw divider finishes earlier than the sine path; its words are held
  // back so both meet the lateral world speed at the stage of the rotation products.
  localparam int unsigned ALIGN_DEPTH = 1 + SINE_LAT - DIV_LAT;

  // Configuration registers. The user must change them only while the pipeline
  // is empty; the block does not enforce it. Every stage reads them directly.
  logic [15:0] fwd_speed_q, lat_amp_q, start_speed_q;
  logic [19:0] osc_freq_q;
  logic [23:0] inv_wb_q;
  logic [31:0] osc_delay_q;
  logic [22:0] start_x_q, stop_x_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_speed_q   <= RST_FWD_SPEED;
      lat_amp_q     <= RST_LAT_AMP;
      osc_freq_q    <= RST_OSC_FREQ;
      inv_wb_q      <= RST_INV_WB;
      osc_delay_q   <= RST_OSC_DELAY;
      start_x_q     <= RST_START_X;
      stop_x_q      <= RST_STOP_X;
      start_speed_q <= RST_START_SPEED;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FWD_SPEED:   fwd_speed_q   <= cfg_data_i[15:0];
        REG_LAT_AMP:     lat_amp_q     <= cfg_data_i[15:0];
        REG_OSC_FREQ:    osc_freq_q    <= cfg_data_i[19:0];
        REG_INV_WB:      inv_wb_q      <= cfg_data_i[23:0];
        REG_OSC_DELAY:   osc_delay_q   <= cfg_data_i;
        REG_START_X:     start_x_q     <= cfg_data_i[22:0];
        REG_STOP_X:      stop_x_q      <= cfg_data_i[22:0];
        REG_START_SPEED: start_speed_q <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Flow control. Every stage moves when the output word is taken or absent;
  // bubbles travel as words with a cleared valid bit.
  logic                  en;
  logic                  accept;
  logic [PIPE_DEPTH:1]   vld_q;
  logic [1:0]            phase_q [1:PIPE_DEPTH];
  logic [1:0]            phase_d;

  assign en         = ~(vld_q[PIPE_DEPTH] & out_stall_i);
  assign in_stall_o = ~en;
  assign accept     = in_valid_i & en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-1:1], accept};
    end
  end

  // The stop test wins over the start test when the two ranges overlap.
  logic signed [24:0] x_ext;
  assign x_ext = {pos_x_i[23], pos_x_i};

  always_comb begin
    if (x_ext >= $signed({2'b00, stop_x_q})) begin
      phase_d = PHASE_STOP;
    end else if (x_ext < $signed({2'b00, start_x_q})) begin
      phase_d = PHASE_START;
    end else begin
      phase_d = PHASE_OSC;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phase_q[1] <= phase_d;
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
        phase_q[k] <= phase_q[k-1];
      end
    end
  end

  // Stage 1: time since onset, the quaternion squares and their cross product.
  logic signed [32:0] dt_q;
  logic signed [31:0] ww_q, zz_q, wz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dt_q <= $signed({1'b0, elapsed_time_i}) - $signed({1'b0, osc_delay_q});
      ww_q <= quat_w_i * quat_w_i;
      zz_q <= quat_z_i * quat_z_i;
      wz_q <= quat_w_i * quat_z_i;
    end
  end

  // Stage 2: oscillation angle (Q32) and the divider operands. A zero
  // quaternion is turned into 1/1 and 0/1 so the divider yields cos 1, sin 0.
  logic signed [53:0] prod_q;
  logic signed [32:0] numc_q, nums_q;
  logic        [31:0] den_q;
  logic               qzero;

  assign qzero = (ww_q == 32'sd0) && (zz_q == 32'sd0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= dt_q * $signed({1'b0, osc_freq_q});
      numc_q <= qzero ? 33'sd1 : 33'(ww_q) - 33'(zz_q);
      nums_q <= qzero ? 33'sd0 : 33'(wz_q) <<< 1;
      den_q  <= qzero ? 32'd1 : 32'(ww_q) + 32'(zz_q);
    end
  end

  // Stages 3 to 24: sine of the angle.
  logic [30:0] sin_mag;
  logic        sin_neg;

  spvc_sine u_sine (
    .clk_i     (clk_i),
    .en_i      (en),
    .prod_i    (prod_q),
    .sin_mag_o (sin_mag),
    .sin_neg_o (sin_neg)
  );

  // Stages 3 to 21: cos and sin of the yaw in Q16, then held to stage 25.
  logic signed [17:0] cos_div, sin_div, cos_al, sin_al;

  spvc_div u_div_cos (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numc_q),
    .den_i (den_q),
    .quo_o (cos_div)
  );

  spvc_div u_div_sin (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nums_q),
    .den_i (den_q),
    .quo_o (sin_div)
  );

  spvc_delay #(
    .WIDTH (36),
    .DEPTH (ALIGN_DEPTH)
  ) u_align (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i ({cos_div, sin_div}),
    .data_o ({cos_al, sin_al})
  );

  // Stage 25: lateral world speed, magnitude truncated before the sign.
  logic        [46:0] vy_prod;
  logic signed [17:0] vy_q;

  assign vy_prod = lat_amp_q * sin_mag;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vy_q <= sin_neg ? -$signed({1'b0, vy_prod[46:30]}) : $signed({1'b0, vy_prod[46:30]});
    end
  end

  // Stage 26: the four rotation products.
  logic signed [35:0] p_cf_q, p_sv_q, p_cv_q, p_sf_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_cf_q <= 36'(cos_al * $signed({1'b0, fwd_speed_q}));
      p_sv_q <= sin_al * vy_q;
      p_cv_q <= cos_al * vy_q;
      p_sf_q <= 36'(sin_al * $signed({1'b0, fwd_speed_q}));
    end
  end

  // Stage 27: body speeds, floored to Q16; forward speed saturated here.
  logic signed [36:0] bx_sum, by_sum;
  logic signed [20:0] bx_w;
  logic signed [19:0] bx_q;
  logic signed [20:0] by_q;

  assign bx_sum = 37'(p_cf_q) + 37'(p_sv_q);
  assign by_sum = 37'(p_cv_q) - 37'(p_sf_q);
  assign bx_w   = bx_sum[36:16];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (bx_w > LIN_MAX) begin
        bx_q <= LIN_MAX[19:0];
      end else if (bx_w < LIN_MIN) begin
        bx_q <= LIN_MIN[19:0];
      end else begin
        bx_q <= bx_w[19:0];
      end
      by_q <= by_sum[36:16];
    end
  end

  // Stage 28: turn rate product.
  logic signed [19:0] bx_d_q;
  logic signed [45:0] tp_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bx_d_q <= bx_q;
      tp_q   <= by_q * $signed({1'b0, inv_wb_q});
    end
  end

  // Stage 29: output register, selecting by phase.
  logic signed [29:0] turn_w;
  logic signed [21:0] turn_sat;
  logic signed [19:0] lin_q;
  logic signed [21:0] turn_q;

  assign turn_w = tp_q[45:16];

  always_comb begin
    if (turn_w > TURN_MAX) begin
      turn_sat = TURN_MAX[21:0];
    end else if (turn_w < TURN_MIN) begin
      turn_sat = TURN_MIN[21:0];
    end else begin
      turn_sat = turn_w[21:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      case (phase_q[PIPE_DEPTH-1])
        PHASE_START: begin
          lin_q  <= $signed({4'b0000, start_speed_q});
          turn_q <= '0;
        end
        PHASE_OSC: begin
          lin_q  <= bx_d_q;
          turn_q <= turn_sat;
        end
        default: begin
          lin_q  <= '0;
          turn_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o    = vld_q[PIPE_DEPTH];
  assign linear_speed_o = lin_q;
  assign turn_rate_o    = turn_q;
  assign phase_o        = phase_q[PIPE_DEPTH];

endmodule

// ----- sv/spvc_sine.sv -----
// ----------------------------------------------------------------------------
// spvc_sine
// Pipelined sine: angle scaling, reduction modulo 2pi, fold to a quarter
// wave and a five-step nested series, at most one multiply per stage.
// ----------------------------------------------------------------------------
module spvc_sine (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [53:0] prod_i,
  output logic        [30:0] sin_mag_o,
  output logic               sin_neg_o
);
  import spvc_pkg::*;

  typedef struct packed {
    logic [31:0] s;
    logic [30:0] r;
    logic        neg;
  } side_t;

  logic signed [51:0] ang_a_q, ang_b_q;
  logic signed [52:0] qm_q;
  logic signed [54:0] qt_q;
  logic signed [35:0] r0_q;
  logic        [32:0] r1_q;
  logic        [30:0] r_q;
  logic               neg_q;
  logic        [61:0] rr_q;
  logic        [30:0] rr_r_q;
  logic               rr_neg_q;

  logic signed [21:0] hi;
  logic signed [20:0] qest;
  logic signed [55:0] diff;
  logic signed [35:0] two_pi_s;
  logic        [32:0] r1_d;
  logic        [31:0] r2;
  logic               neg_d;
  logic        [30:0] r3;

  assign hi       = prod_i[53:32];
  assign qest     = qm_q[52:32];
  assign diff     = 56'(ang_b_q) - 56'(qt_q);
  assign two_pi_s = $signed({3'b000, TWO_PI_Q30});

  always_comb begin
    if (r0_q < 36'sd0) begin
      r1_d = 33'(r0_q + two_pi_s);
    end else if (r0_q >= two_pi_s) begin
      r1_d = 33'(r0_q - two_pi_s);
    end else begin
      r1_d = 33'(r0_q);
    end
  end

  // Fold [0, 2pi) onto [0, pi/2] with a sign.
  always_comb begin
    neg_d = (r1_q >= {1'b0, PI_Q30});
    r2    = neg_d ? 32'(r1_q - {1'b0, PI_Q30}) : r1_q[31:0];
    r3    = (r2 > {1'b0, HALF_PI_Q30}) ? 31'(PI_Q30 - r2) : r2[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_a_q  <= prod_i[53:2];
      qm_q     <= hi * $signed({1'b0, RED_RECIP});
      ang_b_q  <= ang_a_q;
      qt_q     <= qest * $signed({1'b0, TWO_PI_Q30});
      r0_q     <= diff[35:0];
      r1_q     <= r1_d;
      r_q      <= r3;
      neg_q    <= neg_d;
      rr_q     <= r_q * r_q;
      rr_r_q   <= r_q;
      rr_neg_q <= neg_q;
    end
  end

  // Series steps: t = 1 - (s * t) / k, three stages each.
  logic  [62:0] st_q [0:POLY_STEPS-1];
  logic  [69:0] qp_q [0:POLY_STEPS-1];
  logic  [30:0] t_q  [0:POLY_STEPS-1];
  side_t        sa_q [0:POLY_STEPS-1];
  side_t        sb_q [0:POLY_STEPS-1];
  side_t        sc_q [0:POLY_STEPS-1];

  for (genvar j = 0; j < POLY_STEPS; j++) begin : g_step
    logic  [30:0] t_in;
    side_t        sd_in;
    if (j == 0) begin : g_first
      assign t_in  = ONE_Q30;
      assign sd_in = '{s: rr_q[61:30], r: rr_r_q, neg: rr_neg_q};
    end else begin : g_next
      assign t_in  = t_q[j-1];
      assign sd_in = sc_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j] <= sd_in.s * t_in;
        sa_q[j] <= sd_in;
        qp_q[j] <= st_q[j][61:30] * POLY_RECIP[j];
        sb_q[j] <= sa_q[j];
        t_q[j]  <= ONE_Q30 - {1'b0, qp_q[j][69:RECIP_SH]};
        sc_q[j] <= sb_q[j];
      end
    end
  end

  logic [61:0] fin_q;
  logic        fin_neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fin_q     <= sc_q[POLY_STEPS-1].r * t_q[POLY_STEPS-1];
      fin_neg_q <= sc_q[POLY_STEPS-1].neg;
    end
  end

  assign sin_mag_o = fin_q[60:30];
  assign sin_neg_o = fin_neg_q;

endmodule

// ----- sv/spvc_div.sv -----
// ----------------------------------------------------------------------------
// spvc_div
// Pipelined restoring divider, one quotient bit per stage, computing
// (num << 16) / den truncated toward zero for |num| <= den.
// ----------------------------------------------------------------------------
module spvc_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [32:0] num_i,
  input  logic        [31:0] den_i,
  output logic signed [17:0] quo_o
);
  import spvc_pkg::*;

  logic [31:0]          rem_q [0:DIV_QBITS];
  logic [DIV_QBITS-1:0] quo_q [0:DIV_QBITS];
  logic [31:0]          den_q [0:DIV_QBITS];
  logic                 neg_q [0:DIV_QBITS];
  logic                 low_q;
  logic signed [17:0]   res_q;

  logic [32:0] mag;
  assign mag = num_i[32] ? 33'(-num_i) : 33'(num_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= mag[32:1];
      low_q    <= mag[0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= num_i[32];
    end
  end

  for (genvar i = 0; i < DIV_QBITS; i++) begin : g_bit
    logic [32:0] shifted;
    logic        fits;
    if (i == 0) begin : g_top
      assign shifted = {rem_q[i], low_q};
    end else begin : g_low
      assign shifted = {rem_q[i], 1'b0};
    end
    assign fits = (shifted >= {1'b0, den_q[i]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= fits ? 32'(shifted - {1'b0, den_q[i]}) : shifted[31:0];
        quo_q[i+1] <= {quo_q[i][DIV_QBITS-2:0], fits};
        den_q[i+1] <= den_q[i];
        neg_q[i+1] <= neg_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= neg_q[DIV_QBITS] ? -$signed({1'b0, quo_q[DIV_QBITS]})
                                :  $signed({1'b0, quo_q[DIV_QBITS]});
    end
  end

  assign quo_o = res_q;

endmodule

// ----- sv/spvc_delay.sv -----
// ----------------------------------------------------------------------------
// spvc_delay
// Enabled shift line that realigns one datapath branch with another.
// ----------------------------------------------------------------------------
module spvc_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] tap_q [0:DEPTH-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= data_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

// ----- sv/spvc_checker.sv -----
// ----------------------------------------------------------------------------
// spvc_checker
// Port-level checks for the sine path velocity command unit.
// ----------------------------------------------------------------------------
`include "sine_path_velocity_command_unit_assert.svh"

module spvc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic signed [23:0] pos_x_i,
  input logic signed [15:0] quat_z_i,
  input logic signed [15:0] quat_w_i,
  input logic        [31:0] elapsed_time_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [19:0] linear_speed_o,
  input logic signed [21:0] turn_rate_o,
  input logic        [1:0]  phase_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [spvc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic        [31:0] cfg_data_i
);
  import spvc_pkg::*;

  // A reset edge leaves no valid word behind it.
  `SPVC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "valid word after a reset edge")

  `SPVC_ASSERT(a_stop_zero, out_valid_o && phase_o == PHASE_STOP |-> linear_speed_o == 20'sd0 && turn_rate_o == 22'sd0, "stopped word carries motion")

  `SPVC_ASSERT(a_start_straight, out_valid_o && phase_o == PHASE_START |-> turn_rate_o == 22'sd0 && linear_speed_o[19:16] == 4'd0, "start leg word turns or is negative")

  `SPVC_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without a held output word")

  `SPVC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(linear_speed_o) && $stable(turn_rate_o) && $stable(phase_o), "stalled output word changed")

endmodule

bind sine_path_velocity_command_unit spvc_checker u_checker (.*);

// ----- test/sine_path_velocity_command_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine path velocity command unit testbench
// Sends odometry words to the unit through several register settings and
// checks every command word against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------

// Holds the predicted command words in order and compares them against the
// words that the unit delivers.
class command_scoreboard;
  logic [19:0] lin_q[$];
  logic [21:0] turn_q[$];
  logic [1:0]  phase_q[$];
  int errors;
  int checked;

  function void note_command(logic [19:0] lin, logic [21:0] turn, logic [1:0] ph);
    lin_q.push_back(lin);
    turn_q.push_back(turn);
    phase_q.push_back(ph);
  endfunction

  function int pending();
    return lin_q.size();
  endfunction

  function void check_command(logic [19:0] lin, logic [21:0] turn, logic [1:0] ph);
    logic [19:0] el;
    logic [21:0] et;
    logic [1:0]  ep;
    if (lin_q.size() == 0) begin
      $display("%0t: unexpected command word lin=%0d turn=%0d phase=%0d",
               $time, $signed(lin), $signed(turn), ph);
      errors++;
      return;
    end
    el = lin_q.pop_front();
    et = turn_q.pop_front();
    ep = phase_q.pop_front();
    checked++;
    if (el !== lin) begin
      $display("%0t: linear_speed expected %0d actual %0d", $time, $signed(el), $signed(lin));
      errors++;
    end
    if (et !== turn) begin
      $display("%0t: turn_rate expected %0d actual %0d", $time, $signed(et), $signed(turn));
      errors++;
    end
    if (ep !== ph) begin
      $display("%0t: phase expected %0d actual %0d", $time, ep, ph);
      errors++;
    end
  endfunction
endclass

module sine_path_velocity_command_unit_tb;
  import spvc_pkg::*;

  localparam longint TWO_PI = 64'sd6746518852;
  localparam longint PI_V   = 64'sd3373259426;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint ONE_V  = 64'sd1073741824;
  localparam int     LATENCY = 29;
  localparam longint CYCLE_LIMIT = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [23:0] pos_x_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic signed [15:0] quat_w_i = '0;
  logic        [31:0] elapsed_time_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [19:0] linear_speed_o;
  logic signed [21:0] turn_rate_o;
  logic        [1:0]  phase_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic        [31:0] cfg_data_i = '0;

  sine_path_velocity_command_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // The predictor keeps its own copy of the eight registers.
  longint unsigned fwd_speed, lat_amp, osc_freq, inv_wb, osc_delay;
  longint unsigned start_x, stop_x, start_speed;

  command_scoreboard board;
  longint cycles;
  // Idling is switched off during one long stretch of the random part.
  bit     quiet;
  int     items_sent;
  int     osc_seen;

  // Right shift by k, a division by 2^k that rounds toward minus infinity.
  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Truncated series sine of a Q30 angle; the sign is returned separately.
  function automatic longint sine_mag(longint ang, output bit neg);
    longint r, s, t;
    r = ang % TWO_PI;
    if (r < 0) r += TWO_PI;
    neg = 0;
    if (r >= PI_V) begin
      r -= PI_V;
      neg = 1;
    end
    if (r > HALF_PI) r = PI_V - r;
    s = (r * r) >>> 30;
    t = ONE_V - s / 110;
    t = ONE_V - ((s * t) >>> 30) / 72;
    t = ONE_V - ((s * t) >>> 30) / 42;
    t = ONE_V - ((s * t) >>> 30) / 20;
    t = ONE_V - ((s * t) >>> 30) / 6;
    return (r * t) >>> 30;
  endfunction

  // Works out the command word that one odometry word must produce.
  task automatic predict_command(logic signed [23:0] px, logic signed [15:0] qz,
                                 logic signed [15:0] qw, logic [31:0] tm);
    longint x, z, w, ang, smag, vy, n, c, s, bx, by, lin, turn;
    logic [1:0] ph;
    bit neg;
    x = px; z = qz; w = qw;
    lin = 0; turn = 0;
    if (x >= longint'(stop_x)) begin
      ph = PHASE_STOP;
    end else if (x < longint'(start_x)) begin
      ph = PHASE_START;
      lin = start_speed;
    end else begin
      ph = PHASE_OSC;
      ang = floor_shift(longint'(osc_freq) * (longint'(tm) - longint'(osc_delay)), 2);
      smag = sine_mag(ang, neg);
      vy = (longint'(lat_amp) * smag) >>> 30;
      if (neg) vy = -vy;
      n = w * w + z * z;
      if (n == 0) begin
        c = 65536;
        s = 0;
      end else begin
        c = ((w * w - z * z) * 65536) / n;
        s = (2 * w * z * 65536) / n;
      end
      bx = floor_shift(c * longint'(fwd_speed) + s * vy, 16);
      by = floor_shift(c * vy - s * longint'(fwd_speed), 16);
      lin = clamp(bx, -524288, 524287);
      turn = clamp(floor_shift(by * longint'(inv_wb), 16), -2097152, 2097151);
    end
    board.note_command(lin[19:0], turn[21:0], ph);
  endtask

  // Writes one register while the unit is idle and mirrors it in the predictor.
  // Valid then drops before the task returns, so back-to-back writes never collide on valid.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_FWD_SPEED:   fwd_speed   = data[15:0];
      REG_LAT_AMP:     lat_amp     = data[15:0];
      REG_OSC_FREQ:    osc_freq    = data[19:0];
      REG_INV_WB:      inv_wb      = data[23:0];
      REG_OSC_DELAY:   osc_delay   = data;
      REG_START_X:     start_x     = data[22:0];
      REG_STOP_X:      stop_x      = data[22:0];
      REG_START_SPEED: start_speed = data[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Sends one odometry word; valid may stay high into the next word.
  task automatic send_word(logic signed [23:0] px, logic signed [15:0] qz,
                           logic signed [15:0] qw, logic [31:0] tm);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pos_x_i        <= px;
    quat_z_i       <= qz;
    quat_w_i       <= qw;
    elapsed_time_i <= tm;
    do @(posedge clk_i); while (in_stall_o);
    predict_command(px, qz, qw, tm);
    items_sent++;
    if (px < $signed({1'b0, stop_x}) && px >= $signed({1'b0, start_x})) osc_seen++;
  endtask

  // Drops valid, waits for every expected word, then idles for a span derived from LATENCY.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Mostly oscillating-phase positions between the limits, with some outside.
  task automatic random_word();
    logic signed [23:0] px;
    logic signed [15:0] qz, qw;
    logic [31:0] tm;
    int sel;
    sel = $urandom_range(99);
    if (sel < 70 && stop_x > start_x)
      px = 24'($urandom_range(stop_x - 1, start_x));
    else
      px = 24'($urandom);
    qz = 16'($urandom);
    qw = 16'($urandom);
    if ($urandom_range(9) == 0) begin
      qz = '0;
      qw = ($urandom_range(1) != 0) ? 16'sd0 : qw;
    end
    tm = $urandom;
    if ($urandom_range(1) != 0) tm = 32'(osc_delay) + 32'($urandom_range(400000)) - 32'd200000;
    send_word(px, qz, qw, tm);
  endtask

  // Output side: random stalls, checking every accepted command word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.check_command(linear_speed_o, turn_rate_o, phase_o);
      out_stall_i <= !quiet && ($urandom_range(99) < 18);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [31:0] cfg_set[8];
    board = new();
    cycles = 0;
    quiet = 0;
    items_sent = 0;
    osc_seen = 0;
    fwd_speed = RST_FWD_SPEED;  lat_amp = RST_LAT_AMP;  osc_freq = RST_OSC_FREQ;
    inv_wb = RST_INV_WB;  osc_delay = RST_OSC_DELAY;  start_x = RST_START_X;
    stop_x = RST_STOP_X;  start_speed = RST_START_SPEED;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words on reset settings: each phase, the field extremes,
    // a zero quaternion and times before the oscillation onset.
    send_word(24'sh7FFFFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFFFFFF);
    send_word(24'sh800000, 16'sh8000, 16'sh8000, 32'd0);
    send_word(24'sd262144, 16'sd0, 16'sd0, 32'd0);
    send_word(24'sd262143, 16'sd0, 16'sd0, 32'd0);
    send_word(24'sd32768, 16'sd0, 16'sd0, 32'd163840);
    send_word(24'sd32767, 16'sd1000, 16'sd30000, 32'd100);
    send_word(24'sd100000, 16'sh8000, 16'sd0, 32'hFFFFFFFF);
    send_word(24'sd100000, 16'sh7FFF, 16'sh8000, 32'd0);
    send_word(24'sd100000, 16'sd0, 16'sh7FFF, 32'd500000);
    send_word(24'sd100000, 16'sd12000, 16'sd20000, 32'd170000);
    send_word(24'sd200000, -16'sd12000, 16'sd20000, 32'd1);
    drain();

    // Extreme settings, start leg above stop, then everything at zero.
    write_reg(REG_FWD_SPEED, 32'hFFFF);
    write_reg(REG_LAT_AMP, 32'hFFFF);
    write_reg(REG_OSC_FREQ, 32'hFFFFF);
    write_reg(REG_INV_WB, 32'hFFFFFF);
    write_reg(REG_OSC_DELAY, 32'hFFFFFFFF);
    write_reg(REG_START_X, 32'd0);
    write_reg(REG_STOP_X, 32'h7FFFFF);
    write_reg(REG_START_SPEED, 32'hFFFF);
    send_word(24'sd5, 16'sd100, 16'sd0, 32'd0);
    send_word(24'sh7FFFFE, 16'sh8000, 16'sd1, 32'hFFFFFFFF);
    send_word(24'sd0, 16'sd23170, 16'sd23170, 32'h80000000);
    send_word(-24'sd1, 16'sd0, 16'sd0, 32'd0);
    drain();
    write_reg(REG_START_X, 32'h7FFFFF);
    write_reg(REG_STOP_X, 32'd100);
    send_word(24'sd50, 16'sd0, 16'sd0, 32'd0);
    send_word(24'sd200, 16'sd0, 16'sd0, 32'd0);
    send_word(-24'sd200, 16'sd0, 16'sd0, 32'd0);
    drain();
    for (int i = 0; i < 8; i++) write_reg(CFG_IDX_W'(i), 32'd0);
    write_reg(REG_STOP_X, 32'h7FFFFF);
    send_word(24'sd10, 16'sd300, 16'sd7, 32'd12345);
    send_word(24'sh7FFFFE, 16'sh8000, 16'sh8000, 32'hFFFFFFFF);
    drain();

    // Random phases, each on a fresh random register setting.
    for (int phase_n = 0; phase_n < 6; phase_n++) begin
      cfg_set[0] = $urandom;
      cfg_set[1] = $urandom;
      cfg_set[2] = (phase_n == 0) ? 32'd52429 : $urandom;
      cfg_set[3] = (phase_n == 1) ? 32'hFFFFFF : $urandom;
      cfg_set[4] = $urandom;
      cfg_set[5] = $urandom_range(400000);
      cfg_set[6] = 32'($urandom_range(600000, 100000));
      cfg_set[7] = $urandom;
      if (phase_n == 5) cfg_set[6] = 32'h7FFFFF;
      for (int i = 0; i < 8; i++) write_reg(CFG_IDX_W'(i), cfg_set[i]);
      quiet = (phase_n == 2);
      for (int k = 0; k < 160; k++) begin
        random_word();
        // Hold the sender off once until the pipeline has fully emptied.
        if (phase_n == 3 && k == 80) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (board.pending() != 0) @(posedge clk_i);
        end
      end
      quiet = 0;
      drain();
    end

    $display("Sent %0d odometry words, %0d in the oscillating leg; %0d commands checked.",
             items_sent, osc_seen, board.checked);
    $display("Covered start, oscillating and stopped legs over directed and random settings.");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/spvc_pkg.sv
sv/spvc_sine.sv
sv/spvc_div.sv
sv/spvc_delay.sv
sv/sine_path_velocity_command_unit.sv
sv/spvc_checker.sv
test/sine_path_velocity_command_unit_tb.sv
